// ===== rtl/core/civ_tfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package civ_tfp_pkg;

	localparam logic [7:0] BYTE_PRE = 8'hFE;
	localparam logic [7:0] BYTE_END = 8'hFD;

	localparam logic [7:0] ADDR_BCAST  = 8'h00;
	localparam logic [7:0] CMD_FREQ    = 8'h00;
	localparam logic [7:0] CMD_MODE    = 8'h01;
	localparam logic [7:0] MODE_NONE   = 8'hFF;

	// mode bytes on the bus
	localparam logic [7:0] MCODE_LSB = 8'h00;
	localparam logic [7:0] MCODE_USB = 8'h01;
	localparam logic [7:0] MCODE_AM  = 8'h02;
	localparam logic [7:0] MCODE_CW  = 8'h03;
	localparam logic [7:0] MCODE_FM  = 8'h05;
	localparam logic [7:0] MCODE_WFM = 8'h06;
	localparam logic [7:0] MCODE_CWR = 8'h07;

	// demodulator codes
	localparam logic [2:0] DEMOD_AM  = 3'd0;
	localparam logic [2:0] DEMOD_CW  = 3'd1;
	localparam logic [2:0] DEMOD_NFM = 3'd2;
	localparam logic [2:0] DEMOD_LSB = 3'd3;
	localparam logic [2:0] DEMOD_USB = 3'd4;
	localparam logic [2:0] DEMOD_WFM = 3'd5;

	localparam logic EVT_FREQ = 1'b0;
	localparam logic EVT_MODE = 1'b1;

	// register indexes
	localparam logic [2:0] REG_STATION = 3'd0;
	localparam logic [2:0] REG_AM_OFS  = 3'd1;
	localparam logic [2:0] REG_FM_OFS  = 3'd2;
	localparam logic [2:0] REG_CW_OFS  = 3'd3;
	localparam logic [2:0] REG_LSB_OFS = 3'd4;
	localparam logic [2:0] REG_USB_OFS = 3'd5;

	localparam int FREQ_W = 34;
	localparam int OFS_W  = 15;

	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic signed [OFS_W-1:0] ofs_t;

	// weight of frequency byte k (k = 0 is least significant)
	function automatic logic [26:0] pow100(input logic [2:0] k);
		logic [26:0] w;
		case (k)
			3'd0: w = 27'd1;
			3'd1: w = 27'd100;
			3'd2: w = 27'd10000;
			3'd3: w = 27'd1000000;
			3'd4: w = 27'd100000000;
			default: w = 27'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/civ_transceive_frame_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                  payload
// input     in         in_valid / in_stall        rx_byte
// output    out        out_valid / out_stall      event_kind, frequency_hz, demod_code,
//                                                 raw_mode, mode_offset_hz
// config    in         psel / penable / pwrite    paddr, pwdata, prdata on read
//
// one byte per cycle while no event byte waits for the result slot; a byte
// sits in the input register and its event is then taken into the result register.
// the frequency is summed byte by byte as the body arrives (one constant
// multiply and add per byte), so the end marker only selects the event.
// reset clears the parser and both valid flags and sets the registers to their defaults.
// a byte with no event passes even while the result is stalled; a byte that
// makes an event waits in the input register until the result slot is free.

module civ_transceive_frame_parser_core #(
	parameter int MAX_BODY = 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [7:0]                          rx_byte,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     event_kind,
	output civ_tfp_pkg::freq_t                       frequency_hz,
	output logic [2:0]                               demod_code,
	output logic [7:0]                               raw_mode,
	output civ_tfp_pkg::ofs_t                        mode_offset_hz,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [4:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);

	localparam int CNT_W = $clog2(MAX_BODY + 1);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_PRE  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	// configuration registers
	logic [7:0]         station_q;
	civ_tfp_pkg::ofs_t  am_ofs_q, fm_ofs_q, cw_ofs_q, lsb_ofs_q, usb_ofs_q;

	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= 8'h88;
			am_ofs_q  <= '0;
			fm_ofs_q  <= '0;
			cw_ofs_q  <= '0;
			lsb_ofs_q <= '0;
			usb_ofs_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				civ_tfp_pkg::REG_STATION: station_q <= pwdata[7:0];
				civ_tfp_pkg::REG_AM_OFS:  am_ofs_q  <= pwdata[14:0];
				civ_tfp_pkg::REG_FM_OFS:  fm_ofs_q  <= pwdata[14:0];
				civ_tfp_pkg::REG_CW_OFS:  cw_ofs_q  <= pwdata[14:0];
				civ_tfp_pkg::REG_LSB_OFS: lsb_ofs_q <= pwdata[14:0];
				civ_tfp_pkg::REG_USB_OFS: usb_ofs_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			civ_tfp_pkg::REG_STATION: prdata = {24'd0, station_q};
			civ_tfp_pkg::REG_AM_OFS:  prdata = {17'd0, am_ofs_q};
			civ_tfp_pkg::REG_FM_OFS:  prdata = {17'd0, fm_ofs_q};
			civ_tfp_pkg::REG_CW_OFS:  prdata = {17'd0, cw_ofs_q};
			civ_tfp_pkg::REG_LSB_OFS: prdata = {17'd0, lsb_ofs_q};
			civ_tfp_pkg::REG_USB_OFS: prdata = {17'd0, usb_ofs_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       has_res;
	logic       out_free;

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && (!has_res || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// parser state
	logic [1:0]         phase_q, phase_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               ovf_q, ovf_d;
	civ_tfp_pkg::freq_t acc_q, acc_d;
	logic [7:0]         last_mode_q;
	logic [7:0]         hdr_q [4];

	logic               store;
	logic               clear;
	logic               finish;
	logic [7:0]         digit_val;
	logic [2:0]         pw_idx;
	civ_tfp_pkg::freq_t term;

	logic               mode_known;
	logic [2:0]         mode_demod;
	civ_tfp_pkg::ofs_t  mode_ofs;
	logic               freq_ok;
	logic               mode_ok;
	logic               hdr_ok;

	always_comb begin
		phase_d = phase_q;
		store   = 1'b0;
		clear   = 1'b0;
		finish  = 1'b0;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == civ_tfp_pkg::BYTE_PRE) begin
					clear   = 1'b1;
					phase_d = PH_PRE;
				end
			end
			PH_PRE: begin
				if (byte_s1 == civ_tfp_pkg::BYTE_END) begin
					clear   = 1'b1;
					phase_d = PH_HUNT;
				end else if (byte_s1 != civ_tfp_pkg::BYTE_PRE) begin
					store   = 1'b1;
					phase_d = PH_BODY;
				end
			end
			default: begin
				if (byte_s1 == civ_tfp_pkg::BYTE_END) begin
					finish  = 1'b1;
					clear   = 1'b1;
					phase_d = PH_HUNT;
				end else begin
					store = 1'b1;
				end
			end
		endcase
	end

	// bcd byte value hi*10+lo, at most 165
	assign digit_val = 8'({byte_s1[7:4], 3'b000}) + 8'({byte_s1[7:4], 1'b0})
		+ 8'(byte_s1[3:0]);
	assign pw_idx    = 3'(cnt_q - CNT_W'(3));
	assign term      = civ_tfp_pkg::FREQ_W'({26'd0, digit_val}
		* {7'd0, civ_tfp_pkg::pow100(pw_idx)});

	always_comb begin
		cnt_d = cnt_q;
		ovf_d = ovf_q;
		acc_d = acc_q;
		if (clear) begin
			cnt_d = '0;
			ovf_d = 1'b0;
			acc_d = '0;
		end else if (store) begin
			if (cnt_q < CNT_W'(MAX_BODY)) begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q >= CNT_W'(3) && cnt_q <= CNT_W'(7)) begin
					acc_d = acc_q + term;
				end
			end else begin
				ovf_d = 1'b1;
			end
		end
	end

	always_comb begin
		mode_known = 1'b1;
		mode_demod = civ_tfp_pkg::DEMOD_AM;
		mode_ofs   = '0;
		case (hdr_q[3])
			civ_tfp_pkg::MCODE_AM: begin
				mode_demod = civ_tfp_pkg::DEMOD_AM;
				mode_ofs   = am_ofs_q;
			end
			civ_tfp_pkg::MCODE_CW: begin
				mode_demod = civ_tfp_pkg::DEMOD_CW;
				mode_ofs   = cw_ofs_q;
			end
			civ_tfp_pkg::MCODE_CWR: mode_demod = civ_tfp_pkg::DEMOD_CW;
			civ_tfp_pkg::MCODE_FM: begin
				mode_demod = civ_tfp_pkg::DEMOD_NFM;
				mode_ofs   = fm_ofs_q;
			end
			civ_tfp_pkg::MCODE_LSB: begin
				mode_demod = civ_tfp_pkg::DEMOD_LSB;
				mode_ofs   = lsb_ofs_q;
			end
			civ_tfp_pkg::MCODE_USB: begin
				mode_demod = civ_tfp_pkg::DEMOD_USB;
				mode_ofs   = usb_ofs_q;
			end
			civ_tfp_pkg::MCODE_WFM: mode_demod = civ_tfp_pkg::DEMOD_WFM;
			default: mode_known = 1'b0;
		endcase
	end

	assign hdr_ok  = finish && !ovf_q && hdr_q[0] == civ_tfp_pkg::ADDR_BCAST
		&& hdr_q[1] == station_q;
	assign freq_ok = hdr_ok && hdr_q[2] == civ_tfp_pkg::CMD_FREQ && cnt_q == CNT_W'(8);
	assign mode_ok = hdr_ok && hdr_q[2] == civ_tfp_pkg::CMD_MODE && cnt_q == CNT_W'(5)
		&& mode_known && hdr_q[3] != last_mode_q;
	assign has_res = freq_ok || mode_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			acc_q       <= '0;
			last_mode_q <= civ_tfp_pkg::MODE_NONE;
		end else if (advance) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
			acc_q   <= acc_d;
			if (mode_ok) begin
				last_mode_q <= hdr_q[3];
			end
		end
	end

	// header bytes: destination, source, command, mode
	always_ff @(posedge clk) begin
		if (advance && store && cnt_q < CNT_W'(4)) begin
			hdr_q[cnt_q[1:0]] <= byte_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= advance && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && has_res) begin
			if (mode_ok) begin
				event_kind     <= civ_tfp_pkg::EVT_MODE;
				frequency_hz   <= '0;
				demod_code     <= mode_demod;
				raw_mode       <= hdr_q[3];
				mode_offset_hz <= mode_ofs;
			end else begin
				event_kind     <= civ_tfp_pkg::EVT_FREQ;
				frequency_hz   <= acc_q;
				demod_code     <= '0;
				raw_mode       <= '0;
				mode_offset_hz <= '0;
			end
		end
	end

`ifndef SYNTH
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled with a free result slot");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_BODY))
		else $error("body count beyond store depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> cnt_q == CNT_W'(MAX_BODY))
		else $error("overflow flagged with store not full");

	a_freq_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == civ_tfp_pkg::EVT_FREQ
		|-> demod_code == 3'd0 && raw_mode == 8'd0 && mode_offset_hz == '0)
		else $error("mode fields set in a frequency event");

	a_last_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == civ_tfp_pkg::EVT_MODE |-> last_mode_q == raw_mode)
		else $error("last mode does not follow the reported mode");
`endif

endmodule

`default_nettype wire
